// ===== sv/btrc_pkg.sv =====
// ----------------------------------------------------------------------------
// btrc_pkg
// Shared types and constants for the binary trie rank counter.
// ----------------------------------------------------------------------------
package btrc_pkg;

    localparam int KEY_BITS = 32;
    localparam int NODES    = 4096;

    localparam int IDX_W  = $clog2(NODES);
    localparam int FREE_W = $clog2(NODES + 1);
    localparam int LEN_W  = 6;
    localparam int SUM_W  = ((FREE_W > LEN_W) ? FREE_W : LEN_W) + 1;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_LT  = 2'd1,
        CMD_LE  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        key_bits;
        logic [LEN_W-1:0]   key_len;
        logic signed [31:0] weight;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] count;
        logic               pool_full;
    } t_out_item;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [1:0]       valid;
        logic [63:0]      sub_total;
        logic [63:0]      end_total;
    } t_node;

endpackage

// ===== sv/binary_trie_rank_counter_core.sv =====
// ----------------------------------------------------------------------------
// binary_trie_rank_counter_core
// Weighted binary trie in a node memory; adds weights along a key's path and
// counts the weight of keys ordered below a given key.
// Key bits shift out MSB first, one trie level per step.
// Count: each level reads its node and adds its end total (the last node's only for
// LE); on a 1 bit with a left subtree the left child is read too and its subtotal added.
// Add: a check walk over the existing levels finds how many nodes are needed,
// then an update walk reads and rewrites existing nodes and writes new ones whole.
// One item at a time; the single-port node walk sets the rate.
// After reset the root entry is written in S_INIT while input is stalled.
// ----------------------------------------------------------------------------
module binary_trie_rank_counter_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  btrc_pkg::t_in_item   i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output btrc_pkg::t_out_item  o_out_data,
    input  logic                 i_out_stall
);
    import btrc_pkg::*;

    typedef enum logic [10:0] {
        S_INIT     = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_CHK_RD   = 11'b000_0000_0100,
        S_CHK_WT   = 11'b000_0000_1000,
        S_CHK_DEC  = 11'b000_0001_0000,
        S_ADD_RD   = 11'b000_0010_0000,
        S_ADD_WR   = 11'b000_0100_0000,
        S_CNT_RD   = 11'b000_1000_0000,
        S_CNT_EVAL = 11'b001_0000_0000,
        S_CNT_SUB  = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    // node memory
    t_node r_mem [NODES];
    t_node r_rd;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_node            mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    t_state              r_state,     n_state;
    logic [FREE_W-1:0]   r_next_free, n_next_free;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out,       n_out;
    logic [IDX_W-1:0]    r_pos,       n_pos;
    logic [KEY_BITS-1:0] r_key,       n_key;
    logic [KEY_BITS-1:0] r_key_save,  n_key_save;
    logic [LEN_W-1:0]    r_len,       n_len;
    logic [LEN_W-1:0]    r_remain,    n_remain;
    logic [LEN_W-1:0]    r_need,      n_need;
    logic [63:0]         r_w,         n_w;
    logic [63:0]         r_acc,       n_acc;
    logic                r_full,      n_full;
    logic                r_with_eq,   n_with_eq;
    logic                r_fresh,     n_fresh;
    logic [IDX_W-1:0]    r_right,     n_right;
    logic                r_rv,        n_rv;

    logic                bit_b;
    logic [IDX_W-1:0]    child;
    logic                cvalid;
    logic [IDX_W-1:0]    new_idx;
    logic [LEN_W-1:0]    len_c;
    logic [LEN_W-1:0]    align_sh;
    logic [KEY_BITS-1:0] key_aligned;
    logic [SUM_W-1:0]    need_sum;

    assign bit_b   = r_key[KEY_BITS-1];
    assign child   = bit_b ? r_rd.right : r_rd.left;
    assign cvalid  = r_rd.valid[bit_b];
    assign new_idx = r_next_free[IDX_W-1:0];

    assign len_c = (i_in_data.key_len > LEN_W'(KEY_BITS)) ? LEN_W'(KEY_BITS)
                                                          : i_in_data.key_len;
    assign align_sh    = LEN_W'(KEY_BITS) - len_c;
    // first key bit lands in the MSB of the shift register
    assign key_aligned = i_in_data.key_bits[KEY_BITS-1:0] << align_sh;
    assign need_sum    = SUM_W'(r_next_free) + SUM_W'(r_need);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_next_free = r_next_free;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_pos       = r_pos;
        n_key       = r_key;
        n_key_save  = r_key_save;
        n_len       = r_len;
        n_remain    = r_remain;
        n_need      = r_need;
        n_w         = r_w;
        n_acc       = r_acc;
        n_full      = r_full;
        n_with_eq   = r_with_eq;
        n_fresh     = r_fresh;
        n_right     = r_right;
        n_rv        = r_rv;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_pos;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = '0;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key      = key_aligned;
                    n_key_save = key_aligned;
                    n_len      = len_c;
                    n_remain   = len_c;
                    n_pos      = '0;
                    n_w        = {{32{i_in_data.weight[31]}}, i_in_data.weight};
                    n_acc      = '0;
                    n_full     = 1'b0;
                    n_fresh    = 1'b0;
                    n_with_eq  = (i_in_data.command == CMD_LE);
                    unique case (i_in_data.command) inside
                        CMD_ADD:        n_state = S_CHK_RD;
                        CMD_LT, CMD_LE: n_state = S_CNT_RD;
                        default:        n_state = S_DONE;
                    endcase
                end
            end
            // walk existing path to find how many nodes the add would create
            S_CHK_RD: begin
                if (r_remain == '0) begin
                    n_need  = '0;
                    n_state = S_CHK_DEC;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_CHK_WT;
                end
            end
            S_CHK_WT: begin
                if (cvalid) begin
                    n_pos    = child;
                    n_key    = r_key << 1;
                    n_remain = r_remain - 1'b1;
                    n_state  = S_CHK_RD;
                end else begin
                    n_need  = r_remain;
                    n_state = S_CHK_DEC;
                end
            end
            S_CHK_DEC: begin
                if (need_sum > SUM_W'(NODES)) begin
                    n_full  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_key    = r_key_save;
                    n_remain = r_len;
                    n_pos    = '0;
                    n_state  = S_ADD_RD;
                end
            end
            S_ADD_RD: begin
                if (r_fresh) begin
                    // node just allocated: write it whole, no read needed
                    mem_we              = 1'b1;
                    mem_wdata.sub_total = r_w;
                    if (r_remain == '0) begin
                        mem_wdata.end_total = r_w;
                        n_state             = S_DONE;
                    end else begin
                        mem_wdata.valid[bit_b] = 1'b1;
                        if (bit_b) begin
                            mem_wdata.right = new_idx;
                        end else begin
                            mem_wdata.left = new_idx;
                        end
                        n_pos       = new_idx;
                        n_next_free = r_next_free + 1'b1;
                        n_key       = r_key << 1;
                        n_remain    = r_remain - 1'b1;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                mem_we              = 1'b1;
                mem_wdata           = r_rd;
                mem_wdata.sub_total = r_rd.sub_total + r_w;
                if (r_remain == '0) begin
                    mem_wdata.end_total = r_rd.end_total + r_w;
                    n_state             = S_DONE;
                end else begin
                    if (cvalid) begin
                        n_pos = child;
                    end else begin
                        mem_wdata.valid[bit_b] = 1'b1;
                        if (bit_b) begin
                            mem_wdata.right = new_idx;
                        end else begin
                            mem_wdata.left = new_idx;
                        end
                        n_pos       = new_idx;
                        n_next_free = r_next_free + 1'b1;
                        n_fresh     = 1'b1;
                    end
                    n_key    = r_key << 1;
                    n_remain = r_remain - 1'b1;
                    n_state  = S_ADD_RD;
                end
            end
            S_CNT_RD: begin
                mem_re  = 1'b1;
                n_state = S_CNT_EVAL;
            end
            S_CNT_EVAL: begin
                if (r_remain == '0) begin
                    if (r_with_eq) begin
                        n_acc = r_acc + r_rd.end_total;
                    end
                    n_state = S_DONE;
                end else begin
                    n_acc = r_acc + r_rd.end_total;
                    if (!bit_b) begin
                        if (r_rd.valid[0]) begin
                            n_pos    = r_rd.left;
                            n_key    = r_key << 1;
                            n_remain = r_remain - 1'b1;
                            n_state  = S_CNT_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else if (r_rd.valid[0]) begin
                        // everything under the left sibling sorts lower
                        mem_re    = 1'b1;
                        mem_raddr = r_rd.left;
                        n_right   = r_rd.right;
                        n_rv      = r_rd.valid[1];
                        n_state   = S_CNT_SUB;
                    end else if (r_rd.valid[1]) begin
                        n_pos    = r_rd.right;
                        n_key    = r_key << 1;
                        n_remain = r_remain - 1'b1;
                        n_state  = S_CNT_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CNT_SUB: begin
                n_acc = r_acc + r_rd.sub_total;
                if (r_rv) begin
                    n_pos    = r_right;
                    n_key    = r_key << 1;
                    n_remain = r_remain - 1'b1;
                    n_state  = S_CNT_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid     = 1'b1;
                    n_out.count     = r_acc;
                    n_out.pool_full = r_full;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_next_free <= FREE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_key_save <= n_key_save;
        r_len      <= n_len;
        r_remain   <= n_remain;
        r_need     <= n_need;
        r_w        <= n_w;
        r_acc      <= n_acc;
        r_full     <= n_full;
        r_with_eq  <= n_with_eq;
        r_fresh    <= n_fresh;
        r_right    <= n_right;
        r_rv       <= n_rv;
    end

    // nodes are only allocated during the update walk
    a_alloc_only_in_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_ADD_RD || r_state == S_ADD_WR) |=> $stable(r_next_free))
        else $error("node allocated outside add walk");

    // a count never modifies the trie
    a_count_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT_RD || r_state == S_CNT_EVAL || r_state == S_CNT_SUB)
        |-> !mem_we)
        else $error("memory write during count");

    // a fresh node is always the one most recently allocated
    a_fresh_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_RD && r_fresh) |-> (FREE_W'(r_pos) + 1'b1 == r_next_free))
        else $error("fresh node is not the last allocated");

    // a result beat is only launched from the completion state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside completion");

endmodule

// ===== verif/btrc_rank_checker.sv =====
// ----------------------------------------------------------------------------
// btrc_rank_checker
// Watches both channels of the trie rank counter, keeps its own copy of the
// trie, and compares every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module btrc_rank_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  btrc_pkg::t_in_item   i_in_data,
    input  logic                 i_in_stall,
    input  logic                 i_out_valid,
    input  btrc_pkg::t_out_item  i_out_data,
    input  logic                 i_out_stall,
    output int                   o_errors,
    output int                   o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import btrc_pkg::*;

    // Shadow trie
    logic [IDX_W-1:0] trie_left  [NODES];
    logic [IDX_W-1:0] trie_right [NODES];
    logic [1:0]       trie_kids  [NODES];
    logic [63:0]      trie_sub   [NODES];
    logic [63:0]      trie_end   [NODES];
    int unsigned      next_node;

    t_out_item rank_expected_q[$];
    t_out_item got_beat;
    t_out_item want_beat;
    int        mismatches = 0;
    int        waiting    = 0;

    assign o_errors  = mismatches;
    assign o_pending = waiting;

    function automatic int unsigned clamp_len(logic [LEN_W-1:0] len);
        return (len > KEY_BITS) ? KEY_BITS : int'(len);
    endfunction

    function automatic int unsigned missing_nodes(logic [31:0] key, int unsigned len);
        int unsigned pos;
        logic        b;
        pos = 0;
        for (int unsigned i = 0; i < len; i++) begin
            b = key[len - 1 - i];
            if (!trie_kids[pos][b])
                return len - i;
            pos = b ? trie_right[pos] : trie_left[pos];
        end
        return 0;
    endfunction

    // Returns 1 when the add is dropped for lack of nodes.
    function automatic bit trie_add(logic [31:0] key, int unsigned len, logic [63:0] w);
        int unsigned pos;
        int unsigned fresh;
        logic        b;
        if (next_node + missing_nodes(key, len) > NODES)
            return 1'b1;
        pos = 0;
        for (int unsigned i = 0; i < len; i++) begin
            b = key[len - 1 - i];
            trie_sub[pos] += w;
            if (!trie_kids[pos][b]) begin
                fresh = next_node;
                next_node++;
                trie_left[fresh]  = '0;
                trie_right[fresh] = '0;
                trie_kids[fresh]  = '0;
                trie_sub[fresh]   = '0;
                trie_end[fresh]   = '0;
                if (b)
                    trie_right[pos] = IDX_W'(fresh);
                else
                    trie_left[pos] = IDX_W'(fresh);
                trie_kids[pos][b] = 1'b1;
            end
            pos = b ? trie_right[pos] : trie_left[pos];
        end
        trie_sub[pos] += w;
        trie_end[pos] += w;
        return 1'b0;
    endfunction

    function automatic logic [63:0] rank_below(logic [31:0] key, int unsigned len,
                                               bit with_equal);
        logic [63:0] acc;
        int unsigned pos;
        logic        b;
        acc = '0;
        pos = 0;
        for (int unsigned i = 0; i < len; i++) begin
            b = key[len - 1 - i];
            acc += trie_end[pos];
            if (!b) begin
                if (!trie_kids[pos][0])
                    return acc;
                pos = trie_left[pos];
            end else begin
                // everything down the left branch sorts below this key
                if (trie_kids[pos][0])
                    acc += trie_sub[trie_left[pos]];
                if (!trie_kids[pos][1])
                    return acc;
                pos = trie_right[pos];
            end
        end
        if (with_equal)
            acc += trie_end[pos];
        return acc;
    endfunction

    function automatic t_out_item trie_predict(t_in_item beat);
        t_out_item   res;
        int unsigned len;
        len           = clamp_len(beat.key_len);
        res.count     = '0;
        res.pool_full = 1'b0;
        case (beat.command)
            CMD_ADD: res.pool_full = trie_add(beat.key_bits, len,
                                              {{32{beat.weight[31]}}, beat.weight});
            CMD_LT:  res.count = rank_below(beat.key_bits, len, 1'b0);
            CMD_LE:  res.count = rank_below(beat.key_bits, len, 1'b1);
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t checker: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            trie_kids[0] = '0;
            trie_sub[0]  = '0;
            trie_end[0]  = '0;
            next_node    = 1;
            rank_expected_q.delete();
            waiting = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got_beat = i_out_data;
                if (rank_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing pending, count %0h",
                                              got_beat.count));
                end else begin
                    want_beat = rank_expected_q.pop_front();
                    waiting   = rank_expected_q.size();
                    if (got_beat.count !== want_beat.count)
                        report_mismatch($sformatf("count got %0h, want %0h",
                                                  got_beat.count, want_beat.count));
                    if (got_beat.pool_full !== want_beat.pool_full)
                        report_mismatch($sformatf("pool_full got %b, want %b",
                                                  got_beat.pool_full, want_beat.pool_full));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                rank_expected_q.push_back(trie_predict(i_in_data));
                waiting = rank_expected_q.size();
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the trie rank counter with directed corner cases, then random adds
// and queries over three idle/stall profiles; the last starts with a run that
// fills the node pool. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import btrc_pkg::*;

    localparam logic [1:0] CMD_NONE   = 2'd3;
    localparam int         QUIET_MAX  = 2000;
    localparam int         DRAIN_WAIT = 140;

    typedef struct packed {
        logic [31:0]      key;
        logic [LEN_W-1:0] len;
    } t_key;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   errors;
    int   pending;
    int   quiet_cycles = 0;
    t_key known_keys[$];

    binary_trie_rank_counter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall)
    );

    btrc_rank_checker u_rank_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .i_in_stall  (o_in_stall),
        .i_out_valid (o_out_valid),
        .i_out_data  (o_out_data),
        .i_out_stall (out_stall),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_item mk(logic [1:0] cmd, logic [31:0] key,
                                    logic [LEN_W-1:0] len, logic signed [31:0] w);
        t_in_item it;
        it.command  = cmd;
        it.key_bits = key;
        it.key_len  = len;
        it.weight   = w;
        return it;
    endfunction

    // Mostly keys near ones already stored so queries walk deep paths.
    function automatic t_in_item random_beat(bit fill);
        t_in_item    it;
        t_key        k;
        int unsigned roll;
        int unsigned cut;
        int unsigned eff;
        roll = $urandom_range(99);
        if (fill || roll < 40)
            it.command = CMD_ADD;
        else if (roll < 67)
            it.command = CMD_LT;
        else if (roll < 95)
            it.command = CMD_LE;
        else
            it.command = CMD_NONE;

        if (fill) begin
            k.key = $urandom;
            k.len = LEN_W'(KEY_BITS);
        end else if (known_keys.size() > 0 && $urandom_range(99) < 60) begin
            k    = known_keys[$urandom_range(known_keys.size() - 1)];
            eff  = (k.len > KEY_BITS) ? KEY_BITS : int'(k.len);
            roll = $urandom_range(99);
            if (roll < 20 && eff > 0) begin
                cut   = $urandom_range(1, eff);
                k.key = k.key >> cut;
                k.len = LEN_W'(eff - cut);
            end else if (roll < 40 && eff < KEY_BITS) begin
                cut   = $urandom_range(1, KEY_BITS - eff);
                k.key = (k.key << cut) | ($urandom & ((32'd1 << cut) - 32'd1));
                k.len = LEN_W'(eff + cut);
            end else if (roll < 60 && eff > 0) begin
                k.key[0] = ~k.key[0];
            end
        end else begin
            k.key = $urandom;
            k.len = ($urandom_range(99) < 15) ? LEN_W'($urandom_range(33, 63))
                                              : LEN_W'($urandom_range(0, KEY_BITS));
        end
        it.key_bits = k.key;
        it.key_len  = k.len;

        roll = $urandom_range(99);
        if (roll < 5)
            it.weight = 32'sh7FFF_FFFF;
        else if (roll < 10)
            it.weight = 32'sh8000_0000;
        else if (roll < 35)
            it.weight = int'($urandom_range(0, 40)) - 20;
        else
            it.weight = $urandom;

        if (it.command == CMD_ADD) begin
            known_keys.push_back(k);
            if (known_keys.size() > 64)
                void'(known_keys.pop_front());
        end
        return it;
    endfunction

    // Called just after a rising edge; returns at the edge that takes the beat.
    task automatic put_beat(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 27;
        recv_idle_pct = 53;

        // empty trie, empty key
        put_beat(mk(CMD_LT,  32'h0, 6'd0, 32'sd0));
        put_beat(mk(CMD_LE,  32'hFFFF_FFFF, 6'd0, 32'sd9));
        put_beat(mk(CMD_ADD, 32'hFFFF_FFFF, 6'd0, 32'sd5));
        put_beat(mk(CMD_LE,  32'h0, 6'd0, 32'sd0));
        put_beat(mk(CMD_LT,  32'h0, 6'd0, 32'sd0));
        // weight extremes on the longest paths
        put_beat(mk(CMD_ADD, 32'hFFFF_FFFF, 6'd32, 32'sh7FFF_FFFF));
        put_beat(mk(CMD_ADD, 32'h0000_0000, 6'd32, 32'sh8000_0000));
        put_beat(mk(CMD_ADD, 32'hFFFF_FFFF, 6'd32, 32'sh7FFF_FFFF));
        // length above KEY_BITS is clamped
        put_beat(mk(CMD_ADD, 32'hA5A5_A5A5, 6'd63, -32'sd1));
        put_beat(mk(CMD_LE,  32'hFFFF_FFFF, 6'd32, 32'sd0));
        put_beat(mk(CMD_LT,  32'hFFFF_FFFF, 6'd32, 32'sd0));
        put_beat(mk(CMD_LT,  32'h0000_0000, 6'd32, 32'sd0));
        put_beat(mk(CMD_LE,  32'h0000_0000, 6'd32, 32'sd0));
        put_beat(mk(CMD_LE,  32'hA5A5_A5A5, 6'd40, 32'sd0));
        // path breaks off below "11"
        put_beat(mk(CMD_LE,  32'h0000_0006, 6'd3, 32'sd0));
        // bits above the length are ignored
        put_beat(mk(CMD_ADD, 32'hFFFF_FFF2, 6'd2, 32'sd7));
        put_beat(mk(CMD_LE,  32'h0000_0002, 6'd2, 32'sd0));
        put_beat(mk(CMD_LT,  32'h8000_0000, 6'd32, 32'sd0));
        put_beat(mk(CMD_NONE, 32'hFFFF_FFFF, 6'd63, -32'sd1));
        put_beat(mk(CMD_ADD, 32'h0000_0001, 6'd1, 32'sd0));
        put_beat(mk(CMD_LT,  32'h0000_0001, 6'd1, 32'sd0));
        put_beat(mk(CMD_LE,  32'h0000_0001, 6'd1, 32'sd0));
        put_beat(mk(CMD_LT,  32'hFFFF_FFFF, 6'd33, 32'sd0));

        repeat (160) put_beat(random_beat(1'b0));

        send_idle_pct = 53;
        recv_idle_pct = 27;
        repeat (160) put_beat(random_beat(1'b0));

        // back to back; long fresh keys drive the pool to full
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (160) put_beat(random_beat(1'b1));
        repeat (40) put_beat(random_beat(1'b0));

        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
